/* src/gds_pkg.sv */
package gds_pkg;

  // Field widths
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;

  // Calendar limits
  localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
  localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
  localparam logic [DAY_W-1:0]   DAYS_LONG = 5'd31;

  // Divisibility by 25: y % 25 == 0 iff (y * MUL) mod 2^SHIFT < MUL,
  // with MUL = ceil(2^SHIFT / 25) and SHIFT >= YEAR_W + 5
  localparam int unsigned DIV25_SHIFT = 20;
  localparam int unsigned DIV25_MUL_W = 16;
  localparam logic [DIV25_MUL_W-1:0] DIV25_MUL =
    DIV25_MUL_W'(((1 << DIV25_SHIFT) + 24) / 25);

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } gds_in_t;

  typedef struct packed {
    logic               date_valid;
    logic [DAY_W-1:0]   month_days;
    logic [DAY_W-1:0]   next_day;
    logic [MONTH_W-1:0] next_month;
    logic [YEAR_W-1:0]  next_year;
    logic [DAY_W-1:0]   prev_day;
    logic [MONTH_W-1:0] prev_month;
    logic [YEAR_W-1:0]  prev_year;
  } gds_out_t;

  // Length of a month; zero for a month number that names no month
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    len = '0;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = '0;
    endcase
    return len;
  endfunction

endpackage

/* src/gregorian_date_step_core.sv */
// Channel   Ports                          Handshake
// input     start, busy, in_data           taken when start is high and busy is low
// result    out_strobe, out_data           shown for one cycle, no back-pressure
//
// One date per clock; busy is always low. A result is strobed once its item
// has passed the input register, which feeds the validity/step logic, and
// the result register, which captures that logic's output.
// Reset (rst_n low, synchronous) drops any item in flight.
// The receiver cannot stall; every result is strobed exactly once.
module gregorian_date_step_core
  import gds_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  gds_in_t  in_data,
  output logic     out_strobe,
  output gds_out_t out_data
);

  logic     in_vld_r;
  logic     in_vld_nxt;
  gds_in_t  in_r;
  logic     out_vld_r;
  gds_out_t out_r;
  gds_out_t res_nxt;

  assign busy       = 1'b0;
  assign in_vld_nxt = start && !busy;

  // Hold the taken item for the step logic
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_nxt) begin
      in_r <= in_data;
    end
  end

  gds_step u_step (
    .item (in_r),
    .res  (res_nxt)
  );

  // Register the result and strobe it for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      out_r <= res_nxt;
    end
  end

  assign out_strobe = out_vld_r;
  assign out_data   = out_r;

endmodule

/* src/gds_leap.sv */
module gds_leap
  import gds_pkg::*;
(
  input  logic [YEAR_W-1:0] year,
  output logic              leap
);

  localparam int unsigned PROD_W = YEAR_W + DIV25_MUL_W;

  logic [PROD_W-1:0]      prod;
  logic [DIV25_SHIFT-1:0] prod_lo;
  logic                   by25;
  logic                   by4;
  logic                   by16;

  // Test divisibility by 25 with one constant multiply
  assign prod    = PROD_W'(year) * PROD_W'(DIV25_MUL);
  assign prod_lo = prod[DIV25_SHIFT-1:0];
  assign by25    = prod_lo < DIV25_SHIFT'(DIV25_MUL);

  // Multiples of 4, 100 and 400 from the low bits and the test above
  assign by4  = (year[1:0] == 2'b00);
  assign by16 = (year[3:0] == 4'b0000);
  assign leap = (by16 && by25) || (by4 && !by25);

endmodule

/* src/gds_step.sv */
module gds_step
  import gds_pkg::*;
(
  input  gds_in_t  item,
  output gds_out_t res
);

  logic               leap;
  logic [DAY_W-1:0]   len;
  logic               valid;
  logic [DAY_W-1:0]   nd;
  logic [MONTH_W-1:0] nm;
  logic [YEAR_W-1:0]  ny;
  logic [DAY_W-1:0]   pd;
  logic [MONTH_W-1:0] pm;
  logic [YEAR_W-1:0]  py;

  gds_leap u_leap (
    .year (item.year),
    .leap (leap)
  );

  // Check the date against its month's length
  assign len   = month_len(item.month, leap);
  assign valid = (item.year >= YEAR_MIN) && (item.year <= YEAR_MAX) &&
                 (item.month >= MONTH_JAN) && (item.month <= MONTH_DEC) &&
                 (item.day >= DAY_FIRST) && (item.day <= len);

  // Advance one day, rolling month and year
  always_comb begin
    nd = item.day + DAY_W'(1);
    nm = item.month;
    ny = item.year;
    if (item.day == len) begin
      nd = DAY_FIRST;
      if (item.month == MONTH_DEC) begin
        nm = MONTH_JAN;
        ny = item.year + YEAR_W'(1);
      end else begin
        nm = item.month + MONTH_W'(1);
      end
    end
  end

  // Step back one day; only March looks back into February of the same year
  always_comb begin
    pd = item.day - DAY_W'(1);
    pm = item.month;
    py = item.year;
    if (item.day == DAY_FIRST) begin
      if (item.month == MONTH_JAN) begin
        pm = MONTH_DEC;
        py = item.year - YEAR_W'(1);
        pd = DAYS_LONG;
      end else begin
        pm = item.month - MONTH_W'(1);
        pd = month_len(pm, leap);
      end
    end
  end

  // Zero every field of an invalid date
  always_comb begin
    res = '0;
    if (valid) begin
      res.date_valid = 1'b1;
      res.month_days = len;
      res.next_day   = nd;
      res.next_month = nm;
      res.next_year  = ny;
      res.prev_day   = pd;
      res.prev_month = pm;
      res.prev_year  = py;
    end
  end

endmodule
